### rtl/core/rrac_pkg.sv
// ----------------------------------------------------------------------------
// Rounded rectangle compositor package
// Register map codes, field widths, configuration and pipeline beat types.
// ----------------------------------------------------------------------------
package rrac_pkg;

  localparam int LEFT_W     = 13;
  localparam int SIZE_W     = 12;
  localparam int RAD_W      = 11;
  localparam int ALPHA_W    = 8;
  localparam int CH_W       = 8;
  localparam int RGB_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 8'd255;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX   = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECT_LEFT     = 3'd0,
    CFG_RECT_TOP      = 3'd1,
    CFG_RECT_WIDTH    = 3'd2,
    CFG_RECT_HEIGHT   = 3'd3,
    CFG_CORNER_RADIUS = 3'd4,
    CFG_FILL_ALPHA    = 3'd5,
    CFG_FILL_COLOR    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [LEFT_W-1:0] rect_left;
    logic signed [LEFT_W-1:0] rect_top;
    logic [SIZE_W-1:0]        rect_width;
    logic [SIZE_W-1:0]        rect_height;
    logic [RAD_W-1:0]         corner_radius;
    logic [ALPHA_W-1:0]       fill_alpha;
    logic [RGB_W-1:0]         fill_color;
  } cfg_t;

  typedef struct packed {
    logic             covered;
    logic [RGB_W-1:0] bg;
  } cov_beat_t;

endpackage

### rtl/core/rrac_pix_in_if.sv
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel carrying a screen position and its background color.
// ----------------------------------------------------------------------------
interface rrac_pix_in_if #(
  parameter int COORD_BITS = 12
);
  import rrac_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [RGB_W-1:0]      background_rgb;

  modport source (output valid, output pixel_x, output pixel_y, output background_rgb,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input background_rgb,
                  output ready);
endinterface

### rtl/core/rrac_pix_out_if.sv
// ----------------------------------------------------------------------------
// Pixel output channel
// Valid/ready channel carrying the coverage flag and the composited color.
// ----------------------------------------------------------------------------
interface rrac_pix_out_if;
  import rrac_pkg::*;

  logic             valid;
  logic             ready;
  logic             covered;
  logic [RGB_W-1:0] pixel_rgb;

  modport source (output valid, output covered, output pixel_rgb, input ready);
  modport sink   (input valid, input covered, input pixel_rgb, output ready);
endinterface

### rtl/core/rrac_geom.sv
// ----------------------------------------------------------------------------
// Coverage pipeline
// Four stages: offsets, box/band/corner flags, squares, arc compare.
// ----------------------------------------------------------------------------
module rrac_geom #(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rrac_pkg::cfg_t          cfg_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [COORD_BITS-1:0]   px_i,
  input  logic [COORD_BITS-1:0]   py_i,
  input  logic [rrac_pkg::RGB_W-1:0] bg_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output rrac_pkg::cov_beat_t     beat_o
);
  import rrac_pkg::*;

  localparam int UW = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 2;
  localparam int SQ_W = 2 * RAD_W;

  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1
  logic signed [UW-1:0] px_s, py_s, left_s, top_s;
  logic signed [UW-1:0] u1_d, w1_d, u1_q, w1_q;
  logic [RGB_W-1:0]     bg1_q;

  // stage 2
  logic [SIZE_W-1:0] u12, v12, a2, b2;
  logic [SIZE_W:0]   ur_sum, vr_sum;
  logic              in_x, in_y, band_x, band_y, ua, ub, va, vb;
  logic [RAD_W-1:0]  dxl_d, dxr_d, dyt_d, dyb_d;
  logic              inside2_q, band2_q;
  logic [3:0]        sel2_q;
  logic [RAD_W-1:0]  dxl_q, dxr_q, dyt_q, dyb_q;
  logic [RGB_W-1:0]  bg2_q;

  // stage 3
  logic              inside3_q, band3_q;
  logic [3:0]        sel3_q;
  logic [SQ_W-1:0]   sxl_q, sxr_q, syt_q, syb_q, rsq_q;
  logic [RGB_W-1:0]  bg3_q;

  // stage 4
  logic [3:0]        hit;
  logic [SQ_W:0]     d0, d1, d2, d3;
  cov_beat_t         beat4_q;

  assign en4     = !v4_q || ready_i;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v4_q;
  assign beat_o  = beat4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  assign px_s   = $signed({{(UW-COORD_BITS){1'b0}}, px_i});
  assign py_s   = $signed({{(UW-COORD_BITS){1'b0}}, py_i});
  assign left_s = $signed({{(UW-LEFT_W){cfg_i.rect_left[LEFT_W-1]}}, cfg_i.rect_left});
  assign top_s  = $signed({{(UW-LEFT_W){cfg_i.rect_top[LEFT_W-1]}}, cfg_i.rect_top});
  assign u1_d   = px_s - left_s;
  assign w1_d   = py_s - top_s;

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      u1_q  <= u1_d;
      w1_q  <= w1_d;
      bg1_q <= bg_i;
    end
  end

  always_comb begin
    u12    = u1_q[SIZE_W-1:0];
    v12    = w1_q[SIZE_W-1:0];
    in_x   = !u1_q[UW-1] && (u1_q[UW-2:0] < (UW-1)'(cfg_i.rect_width));
    in_y   = !w1_q[UW-1] && (w1_q[UW-2:0] < (UW-1)'(cfg_i.rect_height));
    ur_sum = {1'b0, u12} + (SIZE_W+1)'(cfg_i.corner_radius);
    vr_sum = {1'b0, v12} + (SIZE_W+1)'(cfg_i.corner_radius);
    band_x = (u12 >= SIZE_W'(cfg_i.corner_radius)) && (ur_sum < {1'b0, cfg_i.rect_width});
    band_y = (v12 >= SIZE_W'(cfg_i.corner_radius)) && (vr_sum < {1'b0, cfg_i.rect_height});
    a2     = cfg_i.rect_width - SIZE_W'(1) - u12;
    b2     = cfg_i.rect_height - SIZE_W'(1) - v12;
    ua     = u12 < SIZE_W'(cfg_i.corner_radius);
    ub     = a2 < SIZE_W'(cfg_i.corner_radius);
    va     = v12 < SIZE_W'(cfg_i.corner_radius);
    vb     = b2 < SIZE_W'(cfg_i.corner_radius);
    dxl_d  = cfg_i.corner_radius - u12[RAD_W-1:0];
    dxr_d  = cfg_i.corner_radius - a2[RAD_W-1:0];
    dyt_d  = cfg_i.corner_radius - v12[RAD_W-1:0];
    dyb_d  = cfg_i.corner_radius - b2[RAD_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      inside2_q <= in_x && in_y;
      band2_q   <= band_x || band_y;
      sel2_q    <= {ub && vb, ub && va, ua && vb, ua && va};
      dxl_q     <= dxl_d;
      dxr_q     <= dxr_d;
      dyt_q     <= dyt_d;
      dyb_q     <= dyb_d;
      bg2_q     <= bg1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      inside3_q <= inside2_q;
      band3_q   <= band2_q;
      sel3_q    <= sel2_q;
      sxl_q     <= SQ_W'(dxl_q) * SQ_W'(dxl_q);
      sxr_q     <= SQ_W'(dxr_q) * SQ_W'(dxr_q);
      syt_q     <= SQ_W'(dyt_q) * SQ_W'(dyt_q);
      syb_q     <= SQ_W'(dyb_q) * SQ_W'(dyb_q);
      rsq_q     <= SQ_W'(cfg_i.corner_radius) * SQ_W'(cfg_i.corner_radius);
      bg3_q     <= bg2_q;
    end
  end

  always_comb begin
    d0  = {1'b0, sxl_q} + {1'b0, syt_q};
    d1  = {1'b0, sxl_q} + {1'b0, syb_q};
    d2  = {1'b0, sxr_q} + {1'b0, syt_q};
    d3  = {1'b0, sxr_q} + {1'b0, syb_q};
    hit = {sel3_q[3] && (d3 <= {1'b0, rsq_q}),
           sel3_q[2] && (d2 <= {1'b0, rsq_q}),
           sel3_q[1] && (d1 <= {1'b0, rsq_q}),
           sel3_q[0] && (d0 <= {1'b0, rsq_q})};
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      beat4_q.covered <= inside3_q && (band3_q || (|hit));
      beat4_q.bg      <= bg3_q;
    end
  end

endmodule

### rtl/core/rrac_blend.sv
// ----------------------------------------------------------------------------
// Blend pipeline
// Two stages: per-channel weighted products, then exact divide by 255 and
// select of blended or background color.
// ----------------------------------------------------------------------------
module rrac_blend (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rrac_pkg::cfg_t             cfg_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  rrac_pkg::cov_beat_t        beat_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic                       covered_o,
  output logic [rrac_pkg::RGB_W-1:0] rgb_o
);
  import rrac_pkg::*;

  localparam int NCH   = RGB_W / CH_W;
  localparam int SUM_W = 2 * CH_W;

  logic en5, en6;
  logic v5_q, v6_q;

  logic [ALPHA_W-1:0]          na;
  logic [NCH-1:0][SUM_W-1:0]   sum_d, sum_q;
  logic                        cov5_q;
  logic [RGB_W-1:0]            bg5_q;

  logic [NCH-1:0][SUM_W:0]     div_t;
  logic [NCH-1:0][CH_W-1:0]    q;
  logic                        cov6_q;
  logic [RGB_W-1:0]            rgb6_q;

  assign en6       = !v6_q || ready_i;
  assign en5       = !v5_q || en6;
  assign ready_o   = en5;
  assign valid_o   = v6_q;
  assign covered_o = cov6_q;
  assign rgb_o     = rgb6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en5) v5_q <= valid_i;
      if (en6) v6_q <= v5_q;
    end
  end

  always_comb begin
    na = ALPHA_MAX - cfg_i.fill_alpha;
    for (int c = 0; c < NCH; c++) begin
      sum_d[c] = SUM_W'(cfg_i.fill_color[c*CH_W +: CH_W]) * SUM_W'(cfg_i.fill_alpha)
               + SUM_W'(beat_i.bg[c*CH_W +: CH_W]) * SUM_W'(na);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5 && valid_i) begin
      sum_q  <= sum_d;
      cov5_q <= beat_i.covered;
      bg5_q  <= beat_i.bg;
    end
  end

  // x / 255 == (x + 1 + (x >> 8)) >> 8 over the product range
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      div_t[c] = {1'b0, sum_q[c]} + (SUM_W+1)'(1) + (SUM_W+1)'(sum_q[c][SUM_W-1:CH_W]);
      q[c]     = div_t[c][CH_W +: CH_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6 && v5_q) begin
      cov6_q <= cov5_q;
      rgb6_q <= cov5_q ? q : bg5_q;
    end
  end

endmodule

### rtl/core/rounded_rect_alpha_compositor.sv
// ----------------------------------------------------------------------------
// Rounded rectangle alpha compositor
// Pipeline: an accepted input beat passes through the geometry stages, then
// the blend stages. Throughput: one pixel per cycle through six register
// stages, each with its own valid bit; a stalled output holds the stages behind it.
// Reset: pipeline valid bits clear; fill_alpha returns to 255 and all other
// configuration registers to 0.
// ----------------------------------------------------------------------------
module rounded_rect_alpha_compositor #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rrac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rrac_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rrac_pix_in_if.sink                     pix_in,
  rrac_pix_out_if.source                  pix_out
);
  import rrac_pkg::*;

  cfg_t      cfg_q;
  logic      geom_valid, geom_ready;
  cov_beat_t geom_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rect_left     <= '0;
      cfg_q.rect_top      <= '0;
      cfg_q.rect_width    <= '0;
      cfg_q.rect_height   <= '0;
      cfg_q.corner_radius <= '0;
      cfg_q.fill_alpha    <= ALPHA_RESET;
      cfg_q.fill_color    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RECT_LEFT:     cfg_q.rect_left     <= cfg_data_i[LEFT_W-1:0];
        CFG_RECT_TOP:      cfg_q.rect_top      <= cfg_data_i[LEFT_W-1:0];
        CFG_RECT_WIDTH:    cfg_q.rect_width    <= cfg_data_i[SIZE_W-1:0];
        CFG_RECT_HEIGHT:   cfg_q.rect_height   <= cfg_data_i[SIZE_W-1:0];
        CFG_CORNER_RADIUS: cfg_q.corner_radius <= cfg_data_i[RAD_W-1:0];
        CFG_FILL_ALPHA:    cfg_q.fill_alpha    <= cfg_data_i[ALPHA_W-1:0];
        CFG_FILL_COLOR:    cfg_q.fill_color    <= cfg_data_i[RGB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rrac_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (pix_in.valid),
    .ready_o (pix_in.ready),
    .px_i    (pix_in.pixel_x),
    .py_i    (pix_in.pixel_y),
    .bg_i    (pix_in.background_rgb),
    .valid_o (geom_valid),
    .ready_i (geom_ready),
    .beat_o  (geom_beat)
  );

  rrac_blend u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (geom_valid),
    .ready_o   (geom_ready),
    .beat_i    (geom_beat),
    .valid_o   (pix_out.valid),
    .ready_i   (pix_out.ready),
    .covered_o (pix_out.covered),
    .rgb_o     (pix_out.pixel_rgb)
  );

endmodule
